FILE: rtl/hsr_pkg.sv
// Package for the hue-space to RGB pixel converter.
// Shared constants, operation codes and the structs that travel between pipeline stages.
// No dependencies.
package hsr_pkg;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam int DIV_STEPS = 18;

  typedef enum logic [1:0] {
    OP_HSV = 2'd0,
    OP_HSL = 2'd1,
    OP_HSI = 2'd2
  } op_t;

  typedef struct packed {
    logic        is_hsi;
    logic [2:0]  sext;
    logic [16:0] z;
    logic [16:0] c_pre;
    logic [16:0] m;
    logic [7:0]  pixel;
  } side_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [17:0] d;
    logic [17:0] w;
  } div_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } pix_t;

endpackage

FILE: rtl/hsr_if.sv
// Channel interfaces for the hue-space to RGB pixel converter.
// Valid/ready handshake with payload; no dependencies.
interface hsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] pixel;
  logic [15:0] hue;
  logic [7:0] sat;
  logic [7:0] level;

  modport source(output valid, op, pixel, hue, sat, level, input ready);
  modport sink(input valid, op, pixel, hue, sat, level, output ready);
endinterface

interface hsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;

  modport source(output valid, pixel_out, green, red, blue, input ready);
  modport sink(input valid, pixel_out, green, red, blue, output ready);
endinterface

FILE: rtl/hsr_front.sv
// Front end: byte to Q16 scaling, hue sextant split, products and chroma/offset select.
// Three register stages. Depends on hsr_pkg.
module hsr_front #(
  parameter int PIXEL_COUNT = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [1:0]    op,
  input  logic [7:0]    pixel,
  input  logic [15:0]   hue,
  input  logic [7:0]    sat,
  input  logic [7:0]    level,
  output logic          c_valid,
  output hsr_pkg::side_t c_side,
  output hsr_pkg::div_t  c_div
);

  logic [7:0] pix_mod_tab [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_pix_mod
    assign pix_mod_tab[gi] = 8'(gi % PIXEL_COUNT);
  end

  // stage A
  logic [16:0] s_q_nxt, l_q_nxt, sinv_nxt, span_nxt, z_nxt;
  logic [17:0] two, l_dev;
  logic [18:0] hs;

  always_comb begin
    s_q_nxt  = 17'({sat, sat}) + 17'(sat != 8'd0);
    l_q_nxt  = 17'({level, level}) + 17'(level != 8'd0);
    sinv_nxt = hsr_pkg::ONE_Q16 - s_q_nxt;
    two      = {l_q_nxt, 1'b0};
    l_dev    = (two >= 18'(hsr_pkg::ONE_Q16)) ? two - 18'(hsr_pkg::ONE_Q16)
                                              : 18'(hsr_pkg::ONE_Q16) - two;
    span_nxt = hsr_pkg::ONE_Q16 - l_dev[16:0];
    hs       = 19'(hue) * 19'd6;
    z_nxt    = hs[16] ? hsr_pkg::ONE_Q16 - 17'(hs[15:0]) : 17'(hs[15:0]);
  end

  logic             a_v_r;
  hsr_pkg::op_t     a_op_r;
  logic [7:0]       a_pix_r;
  logic [16:0]      a_s_r, a_l_r, a_sinv_r, a_span_r, a_z_r;
  logic [2:0]       a_sext_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r   <= hsr_pkg::op_t'(op);
      a_pix_r  <= pix_mod_tab[pixel];
      a_s_r    <= s_q_nxt;
      a_l_r    <= l_q_nxt;
      a_sinv_r <= sinv_nxt;
      a_span_r <= span_nxt;
      a_z_r    <= z_nxt;
      a_sext_r <= hs[18:16];
    end
  end

  // stage B: products
  logic             b_v_r;
  hsr_pkg::op_t     b_op_r;
  logic [7:0]       b_pix_r;
  logic [16:0]      b_l_r, b_z_r;
  logic [2:0]       b_sext_r;
  logic [32:0]      b_ls_r, b_hsl_r, b_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_op_r   <= a_op_r;
      b_pix_r  <= a_pix_r;
      b_l_r    <= a_l_r;
      b_z_r    <= a_z_r;
      b_sext_r <= a_sext_r;
      b_ls_r   <= 33'(a_l_r) * 33'(a_s_r);
      b_hsl_r  <= 33'(a_span_r) * 33'(a_s_r);
      b_m_r    <= 33'(a_l_r) * 33'(a_sinv_r);
    end
  end

  // stage C: chroma, offset, divider setup
  logic [16:0]    c_hsv, m_hsv, c_hsl, m_hsl, m_hsi;
  logic [33:0]    num;
  hsr_pkg::side_t side_nxt;
  hsr_pkg::div_t  div_nxt;

  always_comb begin
    c_hsv = b_ls_r[32:16];
    m_hsv = b_l_r - c_hsv;
    c_hsl = b_hsl_r[32:16];
    m_hsl = b_l_r - {1'b0, c_hsl[16:1]};
    m_hsi = b_m_r[32:16];
    num   = {1'b0, b_ls_r} + {b_ls_r, 1'b0};

    side_nxt.sext  = b_sext_r;
    side_nxt.z     = b_z_r;
    side_nxt.pixel = b_pix_r;
    case (b_op_r)
      hsr_pkg::OP_HSL: begin
        side_nxt.is_hsi = 1'b0;
        side_nxt.c_pre  = c_hsl;
        side_nxt.m      = m_hsl;
      end
      hsr_pkg::OP_HSI: begin
        side_nxt.is_hsi = 1'b1;
        side_nxt.c_pre  = c_hsv;
        side_nxt.m      = m_hsi;
      end
      default: begin
        side_nxt.is_hsi = 1'b0;
        side_nxt.c_pre  = c_hsv;
        side_nxt.m      = m_hsv;
      end
    endcase

    div_nxt.rem = 17'(num[33:18]);
    div_nxt.d   = 18'(hsr_pkg::ONE_Q16) + 18'(b_z_r);
    div_nxt.w   = num[17:0];
  end

  logic           c_v_r;
  hsr_pkg::side_t c_side_r;
  hsr_pkg::div_t  c_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= side_nxt;
      c_div_r  <= div_nxt;
    end
  end

  assign c_valid = c_v_r;
  assign c_side  = c_side_r;
  assign c_div   = c_div_r;

endmodule

FILE: rtl/hsr_div_step.sv
// One restoring division step for HSI chroma: one quotient bit per stage.
// Quotient bits shift into the low end as dividend bits leave the top. Depends on hsr_pkg.
module hsr_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hsr_pkg::side_t in_side,
  input  hsr_pkg::div_t  in_div,
  output logic           out_valid,
  output hsr_pkg::side_t out_side,
  output hsr_pkg::div_t  out_div
);

  logic [17:0]   t;
  logic          ge;
  hsr_pkg::div_t div_nxt;

  always_comb begin
    t           = {in_div.rem, in_div.w[17]};
    ge          = (t >= in_div.d);
    div_nxt.rem = ge ? 17'(t - in_div.d) : t[16:0];
    div_nxt.d   = in_div.d;
    div_nxt.w   = {in_div.w[16:0], ge};
  end

  logic           v_r;
  hsr_pkg::side_t side_r;
  hsr_pkg::div_t  div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      div_r  <= div_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_side  = side_r;
  assign out_div   = div_r;

endmodule

FILE: rtl/hsr_back.sv
// Back end: secondary component multiply, sextant routing and byte conversion.
// One register stage, then combinational result item. Depends on hsr_pkg.
module hsr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hsr_pkg::side_t in_side,
  input  hsr_pkg::div_t  in_div,
  output logic           item_valid,
  output hsr_pkg::pix_t  item
);

  function automatic logic [7:0] to_byte(input logic [18:0] comp);
    logic [26:0] t;
    begin
      t = {comp, 8'd0} - 27'(comp);
      return (t[26:24] != 3'd0) ? 8'hFF : t[23:16];
    end
  endfunction

  logic [17:0] c_sel;
  logic [34:0] prod;

  always_comb begin
    c_sel = in_side.is_hsi ? in_div.w : 18'(in_side.c_pre);
    prod  = 35'(c_sel) * 35'(in_side.z);
  end

  logic        d_v_r;
  logic [17:0] d_c_r, d_x_r;
  logic [16:0] d_m_r;
  logic [2:0]  d_sext_r;
  logic [7:0]  d_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_c_r    <= c_sel;
      d_x_r    <= prod[33:16];
      d_m_r    <= in_side.m;
      d_sext_r <= in_side.sext;
      d_pix_r  <= in_side.pixel;
    end
  end

  logic [18:0] cm, xm, mm, r, g, b;

  always_comb begin
    cm = 19'(d_c_r) + 19'(d_m_r);
    xm = 19'(d_x_r) + 19'(d_m_r);
    mm = 19'(d_m_r);
    case (d_sext_r)
      3'd0: begin
        r = cm; g = xm; b = mm;
      end
      3'd1: begin
        r = xm; g = cm; b = mm;
      end
      3'd2: begin
        r = mm; g = cm; b = xm;
      end
      3'd3: begin
        r = mm; g = xm; b = cm;
      end
      3'd4: begin
        r = xm; g = mm; b = cm;
      end
      default: begin
        r = cm; g = mm; b = xm;
      end
    endcase
    item.pixel_out = d_pix_r;
    item.green     = to_byte(g);
    item.red       = to_byte(r);
    item.blue      = to_byte(b);
  end

  assign item_valid = d_v_r;

endmodule

FILE: rtl/hue_space_to_rgb_pixel_core.sv
// Hue-space to RGB pixel converter, top level: front end, divider chain, back end, output queue.
// Depends on hsr_pkg, hsr_if, hsr_front, hsr_div_step and hsr_back.
//
// Takes one HSV/HSL/HSI transaction per clock while the output queue is not full, and returns
// green, red and blue bytes with the pixel index (modulo PIXEL_COUNT). The accepting edge loads
// the first of three front stages; a result then passes an 18-stage restoring divider for HSI
// chroma (one quotient bit per stage, used by every transaction to keep order), one back stage
// and a two-entry output queue before it shows on out_chan. The queue keeps input acceptance
// going while a result waits; when it is full the whole pipeline holds.
module hue_space_to_rgb_pixel_core #(
  parameter int PIXEL_COUNT = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  hsr_in_if.sink    in_chan,
  hsr_out_if.source out_chan
);

  localparam int NSTEP = hsr_pkg::DIV_STEPS;

  logic en;
  logic push, pop;

  logic           v_div    [NSTEP + 1];
  hsr_pkg::side_t side_div [NSTEP + 1];
  hsr_pkg::div_t  div_div  [NSTEP + 1];

  hsr_front #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_chan.valid),
    .op      (in_chan.op),
    .pixel   (in_chan.pixel),
    .hue     (in_chan.hue),
    .sat     (in_chan.sat),
    .level   (in_chan.level),
    .c_valid (v_div[0]),
    .c_side  (side_div[0]),
    .c_div   (div_div[0])
  );

  for (genvar gs = 0; gs < NSTEP; gs++) begin : g_div
    hsr_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v_div[gs]),
      .in_side  (side_div[gs]),
      .in_div   (div_div[gs]),
      .out_valid(v_div[gs + 1]),
      .out_side (side_div[gs + 1]),
      .out_div  (div_div[gs + 1])
    );
  end

  logic          item_valid;
  hsr_pkg::pix_t item;

  hsr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_div[NSTEP]),
    .in_side   (side_div[NSTEP]),
    .in_div    (div_div[NSTEP]),
    .item_valid(item_valid),
    .item      (item)
  );

  // output queue
  hsr_pkg::pix_t fifo_mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r, count_nxt;

  assign en   = (count_r != 2'd2);
  assign push = en && item_valid;
  assign pop  = out_chan.valid && out_chan.ready;

  assign in_chan.ready = en;

  always_comb begin
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem_r[wr_ptr_r] <= item;
    end
  end

  assign out_chan.valid     = (count_r != 2'd0);
  assign out_chan.pixel_out = fifo_mem_r[rd_ptr_r].pixel_out;
  assign out_chan.green     = fifo_mem_r[rd_ptr_r].green;
  assign out_chan.red       = fifo_mem_r[rd_ptr_r].red;
  assign out_chan.blue      = fifo_mem_r[rd_ptr_r].blue;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("output queue count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> out_chan.valid)
    else $error("queued result not presented");

  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_div[0] |-> (side_div[0].c_pre <= hsr_pkg::ONE_Q16))
    else $error("HSV/HSL chroma above full scale");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_div[NSTEP] |-> ({1'b0, div_div[NSTEP].rem} < div_div[NSTEP].d))
    else $error("divider remainder not below divisor");

endmodule
